@@ hw/rtl/mtmd_pkg.sv @@
`timescale 1ns / 1ps
package mtmd_pkg;
   localparam int IN_W            = 32;
   localparam int OUT_W           = 43;
   localparam int DEF_MAX_POINTS  = 1024;
   localparam int DEF_COORD_BITS  = 32;
   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
endpackage

@@ hw/rtl/mtmd_point_ram.sv @@
`timescale 1ns / 1ps
module mtmd_point_ram #(
   parameter int DEPTH = 1024,
   parameter int W     = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [W-1:0]             wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [W-1:0]             rd_data
);
   logic [W-1:0] mem [DEPTH];
   logic [W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/mtmd_dist_unit.sv @@
`timescale 1ns / 1ps
module mtmd_dist_unit #(
   parameter int COORD_BITS = 32,
   parameter int TW         = 43
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  in_valid,
   input  logic [COORD_BITS-1:0] xi,
   input  logic [COORD_BITS-1:0] yi,
   input  logic [COORD_BITS-1:0] xj,
   input  logic [COORD_BITS-1:0] yj,
   output logic [TW-1:0]         acc,
   output logic                  busy
);
   logic                  v2_ff, v3_ff;
   logic [COORD_BITS-1:0] adx_ff, ady_ff;
   logic [COORD_BITS:0]   dsum_ff;
   logic [TW-1:0]         acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= in_valid;
         v3_ff <= v2_ff;
      end
      adx_ff  <= (xi >= xj) ? xi - xj : xj - xi;
      ady_ff  <= (yi >= yj) ? yi - yj : yj - yi;
      dsum_ff <= {1'b0, adx_ff} + {1'b0, ady_ff};
      if (clear) begin
         acc_ff <= '0;
      end else if (v3_ff) begin
         acc_ff <= acc_ff + TW'(dsum_ff);
      end
   end

   assign acc  = acc_ff;
   assign busy = in_valid | v2_ff | v3_ff;
endmodule

@@ hw/rtl/min_total_manhattan_distance.sv @@
`timescale 1ns / 1ps
// Points load one beat per cycle into a point memory; the beat with last_point
// closes the set (points beyond MAX_POINTS are dropped). With n points stored,
// the block then scans every point against all n points through one shared
// abs-difference/accumulate unit fed by the memory's single read port. Each
// point runs a row setup, a scan over all n points and a pipe drain in turn;
// req_ready is low from the closing beat until the result is registered for rsp_valid.
// A single-point set returns 0; totals above 43 bits saturate.
module min_total_manhattan_distance #(
   parameter int MAX_POINTS = mtmd_pkg::DEF_MAX_POINTS,
   parameter int COORD_BITS = mtmd_pkg::DEF_COORD_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [mtmd_pkg::IN_W-1:0] req_x_coord,
   input  logic [mtmd_pkg::IN_W-1:0] req_y_coord,
   input  logic                      req_last_point,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [mtmd_pkg::OUT_W-1:0] rsp_min_total
);
   import mtmd_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int TW = COORD_BITS + 1 + AW;

   typedef enum logic [2:0] {
      ST_LOAD, ST_ROW_START, ST_ROW_LATCH, ST_SCAN, ST_DRAIN, ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in, n_ff, n_in;
   logic [AW-1:0]         i_ff, i_in, j_ff, j_in;
   logic [COORD_BITS-1:0] xi_ff, xi_in, yi_ff, yi_in;
   logic [TW-1:0]         best_ff, best_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_total_ff, rsp_total_in;
   logic                  v1_ff, v1_in;
   logic                  clr, wr_en, busy;
   logic [AW-1:0]         rd_addr;
   logic [2*COORD_BITS-1:0] rd_data;
   logic [TW-1:0]         acc;

   mtmd_point_ram #(.DEPTH(MAX_POINTS), .W(2 * COORD_BITS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data ({req_y_coord[COORD_BITS-1:0], req_x_coord[COORD_BITS-1:0]}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mtmd_dist_unit #(.COORD_BITS(COORD_BITS), .TW(TW)) u_dist (
      .clock    (clock),
      .reset    (reset),
      .clear    (clr),
      .in_valid (v1_ff),
      .xi       (xi_ff),
      .yi       (yi_ff),
      .xj       (rd_data[COORD_BITS-1:0]),
      .yj       (rd_data[2*COORD_BITS-1:COORD_BITS]),
      .acc      (acc),
      .busy     (busy)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      xi_in        = xi_ff;
      yi_in        = yi_ff;
      best_in      = best_ff;
      rsp_total_in = rsp_total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      v1_in        = 1'b0;
      clr          = 1'b0;
      wr_en        = 1'b0;
      rd_addr      = i_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (cnt_ff < CW'(MAX_POINTS)) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
               if (req_last_point) begin
                  n_in     = cnt_in;
                  i_in     = '0;
                  best_in  = '1;
                  state_in = ST_ROW_START;
               end
            end
         end
         ST_ROW_START: begin
            state_in = ST_ROW_LATCH;
         end
         ST_ROW_LATCH: begin
            xi_in    = rd_data[COORD_BITS-1:0];
            yi_in    = rd_data[2*COORD_BITS-1:COORD_BITS];
            clr      = 1'b1;
            j_in     = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rd_addr = j_ff;
            v1_in   = 1'b1;
            j_in    = j_ff + 1'b1;
            if (CW'(j_ff) == n_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!busy) begin
               if (acc < best_ff) begin
                  best_in = acc;
               end
               if (CW'(i_ff) == n_ff - 1'b1) begin
                  state_in = ST_DONE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_ROW_START;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = (64'(best_ff) > 64'(OUT_MAX)) ? OUT_MAX : OUT_W'(best_ff);
               cnt_in       = '0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= v1_in;
      end
      n_ff         <= n_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      xi_ff        <= xi_in;
      yi_ff        <= yi_in;
      best_ff      <= best_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign req_ready     = (state_ff == ST_LOAD);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_total = rsp_total_ff;

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_POINTS)) else $error("point count over limit");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> CW'(j_ff) < n_ff) else $error("scan index past set");
   a_idle_pipe: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> !busy) else $error("distance pipe busy while loading");
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE)) else $error("stray result");
`endif
endmodule

@@ tb/min_total_manhattan_distance_tb.sv @@
`timescale 1ns / 1ps
module min_total_manhattan_distance_tb;
   import mtmd_pkg::*;

   localparam int NPTS     = DEF_MAX_POINTS;
   localparam int WD_LIMIT = 4_000_000;

   typedef struct {
      logic [IN_W-1:0] x;
      logic [IN_W-1:0] y;
      logic            last;
   } point_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [IN_W-1:0] req_x_coord = '0;
   logic [IN_W-1:0] req_y_coord = '0;
   logic req_last_point = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [OUT_W-1:0] rsp_min_total;

   point_t pending_points[$];
   logic [OUT_W-1:0] expected_totals[$];
   logic [IN_W-1:0] set_x[NPTS];
   logic [IN_W-1:0] set_y[NPTS];
   int set_size = 0;
   int mismatches = 0;
   int points_taken = 0;
   int idle_cycles = 0;
   bit req_fire = 1'b0;
   bit hold_rsp = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_phase = 0;

   min_total_manhattan_distance i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_x_coord(req_x_coord), .req_y_coord(req_y_coord),
      .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_min_total(rsp_min_total)
   );

   always #10 clock = ~clock;

   function automatic logic [OUT_W-1:0] min_total_of_set(int n);
      longint unsigned best, sum, dx, dy;
      best = 0;
      for (int i = 0; i < n; i++) begin
         sum = 0;
         for (int j = 0; j < n; j++) begin
            dx = (set_x[i] > set_x[j]) ? set_x[i] - set_x[j] : set_x[j] - set_x[i];
            dy = (set_y[i] > set_y[j]) ? set_y[i] - set_y[j] : set_y[j] - set_y[i];
            sum += dx + dy;
         end
         if (i == 0 || sum < best) best = sum;
      end
      if (best > longint'(OUT_MAX)) best = OUT_MAX;
      return best[OUT_W-1:0];
   endfunction

   function automatic logic [IN_W-1:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(0, 15);
         2: return $urandom_range(0, 1) ? '1 : '0;
         default: return {$urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom), 16'($urandom)};
      endcase
   endfunction

   task automatic add_point(logic [IN_W-1:0] x, logic [IN_W-1:0] y, logic last);
      point_t p;
      p.x = x;
      p.y = y;
      p.last = last;
      pending_points.push_back(p);
   endtask

   task automatic add_random_set(int n, int mode);
      for (int i = 0; i < n; i++)
         add_point(rand_coord(mode), rand_coord(mode), i == n - 1);
   endtask

   // driver: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         req_valid <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
         point_t p;
         p = pending_points.pop_front();
         req_x_coord <= p.x;
         req_y_coord <= p.y;
         req_last_point <= p.last;
         req_valid <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: own stall pattern, long hold-off on request
   always @(negedge clock) begin
      stall_phase <= (stall_phase + 1) % 64;
      if (reset || hold_rsp)
         rsp_ready <= 1'b0;
      else if (stall_phase < 24)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(0, 2) != 0);
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready && !reset;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WD_LIMIT) begin
            $display("timeout: no beat for %0d cycles", idle_cycles);
            $display("min_total_manhattan_distance_tb: FAIL");
            $finish;
         end
         if (req_valid && req_ready) begin
            points_taken++;
            if (set_size < NPTS) begin
               set_x[set_size] = req_x_coord;
               set_y[set_size] = req_y_coord;
               set_size++;
            end
            if (req_last_point) begin
               expected_totals.push_back(min_total_of_set(set_size));
               set_size = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_totals.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat: min_total=%0d", rsp_min_total);
            end else begin
               logic [OUT_W-1:0] exp_total;
               exp_total = expected_totals.pop_front();
               if (rsp_min_total !== exp_total) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("min_total mismatch: expected %0d, got %0d",
                              exp_total, rsp_min_total);
               end
            end
         end
      end
   end

   // long receiver hold-off while points keep coming
   initial begin
      wait (points_taken >= 1200);
      hold_rsp = 1'b1;
      repeat (3000) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      int n;
      // directed
      add_point('0, '0, 1'b1);
      add_point('1, '1, 1'b1);
      add_point('0, '0, 1'b0);
      add_point('1, '1, 1'b1);
      add_point('0, '1, 1'b0);
      add_point('1, '0, 1'b1);
      add_point(32'd5, 32'd5, 1'b0);
      add_point(32'd5, 32'd5, 1'b0);
      add_point(32'd1, 32'd9, 1'b0);
      add_point(32'haaaa5555, 32'h5555aaaa, 1'b1);
      add_point(32'd3, 32'd7, 1'b0);
      add_point(32'hffff0000, 32'h0000ffff, 1'b0);
      add_point(32'd100, 32'd0, 1'b0);
      add_point(32'd0, 32'd100, 1'b1);
      // overfull set: points past the store size are dropped
      add_random_set(NPTS + 6, 0);
      // random sets, mostly small
      n = 0;
      while (n < 560) begin
         int sz;
         sz = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
         add_random_set(sz, $urandom_range(0, 3));
         n += sz;
      end
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      wait (pending_points.size() == 0);
      wait (!req_valid);
      wait (expected_totals.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_totals.size() == 0)
         $display("min_total_manhattan_distance_tb: PASS");
      else
         $display("min_total_manhattan_distance_tb: FAIL");
      $finish;
   end
endmodule
